// File: hdl/cbpq_pkg.sv
// Shared codes for the circular bucket priority queue.
package cbpq_pkg;

  localparam logic OP_ENQ = 1'b0;
  localparam logic OP_DEQ = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  localparam int unsigned PRIO_W = 32;
  localparam int unsigned DATA_W = 64;

endpackage

// File: hdl/circular_bucket_priority_queue.sv
// Top level: circular bucket priority queue with two halves of bucket FIFOs.
//
// Input stream (s_axis): one word per operation. tuser is the operation,
// 0 enqueue, 1 dequeue. tdata carries the priority and the packet word.
// Output stream (m_axis): exactly one word per operation, in order. tuser is
// the status (ok, bucket full, queue empty), tdata the dequeued word and the
// served priority.
// One operation is in work at a time. The steps run in order: form the bucket
// key and read the pointer memory, for a dequeue read the packet memory at the
// head pointer, and update pointers, memories and the output register. An
// empty-queue dequeue only forms the key and then loads the output register.
// The input is ready again in the cycle the result appears.
// The result sits in an output register; the next word is accepted while it
// waits. If the receiver stalls, the following operation holds in its last
// stage until the register frees.
// Reset clears base, half select, occupancy bitmaps and the pointer valid
// bits at once; no clearing pass, the block is ready right after reset.
module circular_bucket_priority_queue #(
  parameter int unsigned BUCKETS_PER_HALF = 64,
  parameter int unsigned FIFO_DEPTH_LOG2  = 4
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [95:0]  s_axis_tdata,  // priority_req[31:0], packet_data[95:32]
  input  logic         s_axis_tuser,  // operation
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [95:0]  m_axis_tdata,  // data_out[63:0], served_priority[95:64]
  output logic [1:0]   m_axis_tuser   // status
);
  import cbpq_pkg::*;

  localparam int unsigned N  = BUCKETS_PER_HALF;
  localparam int unsigned L  = FIFO_DEPTH_LOG2;
  localparam int unsigned BW = $clog2(N);
  localparam int unsigned KW = BW + 1;
  localparam int unsigned OW = $clog2(2 * N);
  localparam int unsigned PW = L + 1;
  localparam int unsigned AW = KW + L;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_KEY  = 3'd1;
  localparam logic [2:0] S_PTR  = 3'd2;
  localparam logic [2:0] S_POP  = 3'd3;
  localparam logic [2:0] S_EMP  = 3'd4;

  logic [2:0]        state_q, state_d;
  logic              op_q;
  logic [PRIO_W-1:0] prio_q;
  logic [DATA_W-1:0] data_q;
  logic [PRIO_W-1:0] base_q, base_d;
  logic              prim_q, prim_d;
  logic [N-1:0]      occ_q [2];
  logic [N-1:0]      occ_d [2];
  logic              half_q, half_d;
  logic [BW-1:0]     bkt_q, bkt_d;
  logic [PRIO_W-1:0] srv_q, srv_d;

  logic              outv_q, outv_d;
  logic [1:0]        ost_q, ost_d;
  logic [DATA_W-1:0] odata_q, odata_d;
  logic [PRIO_W-1:0] oprio_q, oprio_d;
  logic              out_free, accept;

  logic              ptr_re, ptr_we;
  logic [KW-1:0]     ptr_raddr;
  logic [2*PW-1:0]   ptr_wdata, ptr_rdata;
  logic              st_re, st_we;
  logic [AW-1:0]     st_raddr, st_waddr;
  logic [DATA_W-1:0] st_rdata;

  logic [PRIO_W-1:0] top, clamped, diff;
  logic [OW-1:0]     off;
  logic              busy_p, busy_o, busy_after;
  logic              sel_half;
  logic [BW-1:0]     ffs;
  logic [N-1:0]      ffs_vec, clr_mask;
  logic [PW-1:0]     head, tail, cnt, head_nx, tail_nx;
  logic              pop_empties;

  assign head    = ptr_rdata[PW-1:0];
  assign tail    = ptr_rdata[2*PW-1:PW];
  assign cnt     = tail - head;
  assign head_nx = head + PW'(1);
  assign tail_nx = tail + PW'(1);
  assign pop_empties = (head_nx == tail);

  assign out_free = !outv_q || m_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE);
  assign accept = s_axis_tvalid && s_axis_tready;

  // window clamp; the offset always lands below 2N
  always_comb begin
    top = base_q + PRIO_W'(2 * N);
    if (prio_q >= top) begin
      clamped = top - PRIO_W'(1);
    end else if (prio_q < base_q) begin
      clamped = base_q;
    end else begin
      clamped = prio_q;
    end
    diff = clamped - base_q;
    off  = diff[OW-1:0];
  end

  always_comb begin
    busy_p   = |occ_q[prim_q];
    busy_o   = |occ_q[~prim_q];
    sel_half = busy_p ? prim_q : ~prim_q;
    ffs_vec  = occ_q[sel_half];
    ffs      = '0;
    for (int i = N - 1; i >= 0; i--) begin
      if (ffs_vec[i]) begin
        ffs = BW'(i);
      end
    end
  end

  assign clr_mask   = pop_empties ? ({{(N-1){1'b0}}, 1'b1} << bkt_q) : '0;
  assign busy_after = |(occ_q[half_q] & ~clr_mask);

  always_comb begin
    state_d   = state_q;
    base_d    = base_q;
    prim_d    = prim_q;
    occ_d     = occ_q;
    half_d    = half_q;
    bkt_d     = bkt_q;
    srv_d     = srv_q;
    outv_d    = outv_q && !m_axis_tready;
    ost_d     = ost_q;
    odata_d   = odata_q;
    oprio_d   = oprio_q;
    ptr_re    = 1'b0;
    ptr_raddr = '0;
    ptr_we    = 1'b0;
    ptr_wdata = '0;
    st_re     = 1'b0;
    st_raddr  = {half_q, bkt_q, head[L-1:0]};
    st_we     = 1'b0;
    st_waddr  = {half_q, bkt_q, tail[L-1:0]};

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_KEY;
        end
      end
      S_KEY: begin
        if (op_q == OP_ENQ) begin
          if (off < OW'(N)) begin
            half_d = prim_q;
            bkt_d  = BW'(off);
          end else begin
            half_d = ~prim_q;
            bkt_d  = BW'(off - OW'(N));
          end
          srv_d     = base_q + PRIO_W'(off);
          ptr_re    = 1'b1;
          ptr_raddr = {half_d, bkt_d};
          state_d   = S_PTR;
        end else if (!busy_p && !busy_o) begin
          state_d = S_EMP;
        end else begin
          if (!busy_p) begin
            prim_d = ~prim_q;
            base_d = base_q + PRIO_W'(N);
          end
          half_d    = sel_half;
          bkt_d     = ffs;
          ptr_re    = 1'b1;
          ptr_raddr = {half_d, bkt_d};
          state_d   = S_PTR;
        end
      end
      S_PTR: begin
        if (op_q == OP_DEQ) begin
          st_re   = 1'b1;
          state_d = S_POP;
        end else if (out_free) begin
          outv_d  = 1'b1;
          odata_d = '0;
          oprio_d = srv_q;
          if (cnt[PW-1]) begin
            ost_d = ST_FULL;
          end else begin
            ost_d     = ST_OK;
            st_we     = 1'b1;
            ptr_we    = 1'b1;
            ptr_wdata = {tail_nx, head};
            occ_d[half_q][bkt_q] = 1'b1;
          end
          state_d = S_IDLE;
        end
      end
      S_POP: begin
        if (out_free) begin
          outv_d    = 1'b1;
          ost_d     = ST_OK;
          odata_d   = st_rdata;
          oprio_d   = base_q + PRIO_W'(bkt_q);
          ptr_we    = 1'b1;
          ptr_wdata = {tail, head_nx};
          if (pop_empties) begin
            occ_d[half_q][bkt_q] = 1'b0;
          end
          // primary just drained while the other half holds words
          if (!busy_after && |occ_q[~half_q]) begin
            prim_d = ~prim_q;
            base_d = base_q + PRIO_W'(N);
          end
          state_d = S_IDLE;
        end
      end
      S_EMP: begin
        if (out_free) begin
          outv_d  = 1'b1;
          ost_d   = ST_EMPTY;
          odata_d = '0;
          oprio_d = '0;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      base_q  <= '0;
      prim_q  <= 1'b0;
      occ_q   <= '{default: '0};
      outv_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      base_q  <= base_d;
      prim_q  <= prim_d;
      occ_q   <= occ_d;
      outv_q  <= outv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= s_axis_tuser;
      prio_q <= s_axis_tdata[31:0];
      data_q <= s_axis_tdata[95:32];
    end
    half_q  <= half_d;
    bkt_q   <= bkt_d;
    srv_q   <= srv_d;
    ost_q   <= ost_d;
    odata_q <= odata_d;
    oprio_q <= oprio_d;
  end

  cbpq_ptr_mem #(.KW(KW), .PW(PW)) u_ptr (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .re_i    (ptr_re),
    .raddr_i (ptr_raddr),
    .we_i    (ptr_we),
    .waddr_i ({half_q, bkt_q}),
    .wdata_i (ptr_wdata),
    .rdata_o (ptr_rdata)
  );

  cbpq_store #(.AW(AW)) u_store (
    .clk_i   (clk_i),
    .re_i    (st_re),
    .raddr_i (st_raddr),
    .we_i    (st_we),
    .waddr_i (st_waddr),
    .wdata_i (data_q),
    .rdata_o (st_rdata)
  );

  assign m_axis_tvalid = outv_q;
  assign m_axis_tuser  = ost_q;
  assign m_axis_tdata  = {oprio_q, odata_q};
endmodule

// File: hdl/cbpq_ptr_mem.sv
// Head/tail pointer memory with per-bucket valid bits (unwritten reads as zero).
module cbpq_ptr_mem #(
  parameter int unsigned KW = 7,
  parameter int unsigned PW = 5
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            re_i,
  input  logic [KW-1:0]   raddr_i,
  input  logic            we_i,
  input  logic [KW-1:0]   waddr_i,
  input  logic [2*PW-1:0] wdata_i,
  output logic [2*PW-1:0] rdata_o
);
  localparam int unsigned DEPTH = 1 << KW;

  logic [2*PW-1:0] mem [DEPTH];
  logic [DEPTH-1:0] vld_q;
  logic [2*PW-1:0] rd_q;
  logic            rvld_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rd_q <= mem[raddr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (we_i) begin
        vld_q[waddr_i] <= 1'b1;
      end
      if (re_i) begin
        rvld_q <= vld_q[raddr_i];
      end
    end
  end

  assign rdata_o = rvld_q ? rd_q : '0;
endmodule

// File: hdl/cbpq_store.sv
// Packet word memory, one FIFO slot per entry.
module cbpq_store #(
  parameter int unsigned AW = 11
) (
  input  logic                       clk_i,
  input  logic                       re_i,
  input  logic [AW-1:0]              raddr_i,
  input  logic                       we_i,
  input  logic [AW-1:0]              waddr_i,
  input  logic [cbpq_pkg::DATA_W-1:0] wdata_i,
  output logic [cbpq_pkg::DATA_W-1:0] rdata_o
);
  import cbpq_pkg::*;

  logic [DATA_W-1:0] mem [1 << AW];
  logic [DATA_W-1:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rd_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rd_q;
endmodule

// File: hdl/cbpq_checker.sv
// Port-level checks for the circular bucket priority queue, bound to the top.
module cbpq_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [95:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser
);
  import cbpq_pkg::*;

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser == ST_OK || m_axis_tuser == ST_FULL ||
                       m_axis_tuser == ST_EMPTY))
    else $error("undefined status code");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser == ST_EMPTY) |-> (m_axis_tdata == '0))
    else $error("empty-queue word not zero");

  a_full_nodata: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser == ST_FULL) |-> (m_axis_tdata[63:0] == '0))
    else $error("full-bucket word carries data");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled output word changed");

  a_one_inflight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("second word taken while one is in work");
endmodule

bind circular_bucket_priority_queue cbpq_checker u_cbpq_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

// File: tb/sv/circular_bucket_priority_queue_tb.sv
// Testbench for the circular bucket priority queue: directed and random stream traffic.
`timescale 1ns / 100ps

module circular_bucket_priority_queue_tb;
  import cbpq_pkg::*;

  localparam int unsigned NB = 64;
  localparam int unsigned DEPTH_LOG2 = 4;
  localparam int unsigned DEPTH = 1 << DEPTH_LOG2;
  localparam int unsigned WDOG_LIMIT = 2000;

  typedef struct packed {
    logic [1:0]        status;
    logic [DATA_W-1:0] word;
    logic [PRIO_W-1:0] prio;
  } qres_t;

  logic              clk_i;
  logic              rst_ni;
  logic              s_axis_tvalid;
  logic              s_axis_tready;
  logic [95:0]       s_axis_tdata;
  logic              s_axis_tuser;
  logic              m_axis_tvalid;
  logic              m_axis_tready;
  logic [95:0]       m_axis_tdata;
  logic [1:0]        m_axis_tuser;

  circular_bucket_priority_queue #(
    .BUCKETS_PER_HALF(NB),
    .FIFO_DEPTH_LOG2 (DEPTH_LOG2)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  // predictor state
  logic [PRIO_W-1:0] base_q;
  logic              prim_q;
  logic [NB-1:0]     occ_q [2];
  logic [DEPTH_LOG2:0] head_q [2*NB];
  logic [DEPTH_LOG2:0] tail_q [2*NB];
  logic [DATA_W-1:0] store_q [2*NB*DEPTH];

  qres_t expected_q[$];
  int    mismatches = 0;
  int    wdog = 0;
  bit    done;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int unsigned lowest_set(logic [NB-1:0] v);
    for (int i = 0; i < NB; i++) if (v[i]) return i;
    return 0;
  endfunction

  function automatic qres_t queue_step(logic op, logic [PRIO_W-1:0] prio, logic [DATA_W-1:0] d);
    qres_t r;
    logic [PRIO_W-1:0] top, p, off;
    int unsigned half, b, key;
    r = '0;
    if (op == OP_ENQ) begin
      top = base_q + 2 * NB;
      p = prio;
      if (prio >= top) p = top - 1;
      else if (prio < base_q) p = base_q;
      off = (p - base_q) % (2 * NB);
      if (off < NB) begin
        half = prim_q; b = off;
      end else begin
        half = !prim_q; b = off - NB;
      end
      key = half * NB + b;
      r.prio = base_q + off;
      if (((tail_q[key] - head_q[key]) & {(DEPTH_LOG2+1){1'b1}}) >= DEPTH) begin
        r.status = ST_FULL;
        return r;
      end
      store_q[key * DEPTH + tail_q[key][DEPTH_LOG2-1:0]] = d;
      tail_q[key] = tail_q[key] + 1;
      occ_q[half][b] = 1'b1;
      r.status = ST_OK;
    end else begin
      if (occ_q[prim_q] == '0) begin
        if (occ_q[!prim_q] == '0) begin
          r.status = ST_EMPTY;
          return r;
        end
        prim_q = !prim_q;
        base_q = base_q + NB;
      end
      half = prim_q;
      b = lowest_set(occ_q[half]);
      key = half * NB + b;
      r.word = store_q[key * DEPTH + head_q[key][DEPTH_LOG2-1:0]];
      r.prio = base_q + b;
      r.status = ST_OK;
      if (head_q[key] != tail_q[key]) head_q[key] = head_q[key] + 1;
      if (head_q[key] == tail_q[key]) occ_q[half][b] = 1'b0;
      if (occ_q[half] == '0 && occ_q[!half] != '0) begin
        prim_q = !prim_q;
        base_q = base_q + NB;
      end
    end
    return r;
  endfunction

  // valid stays up after a handshake until the next word or an idle gap
  task automatic send_word(logic op, logic [PRIO_W-1:0] prio, logic [DATA_W-1:0] d);
    int gap;
    gap = $urandom_range(0, 7);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {d, prio};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    expected_q.push_back(queue_step(op, prio, d));
    @(negedge clk_i);
  endtask

  task automatic enq(logic [PRIO_W-1:0] prio, logic [DATA_W-1:0] d);
    send_word(OP_ENQ, prio, d);
  endtask

  task automatic deq();
    send_word(OP_DEQ, $urandom, {$urandom, $urandom});
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    @(negedge clk_i);
    while (expected_q.size() != 0) @(negedge clk_i);
  endtask

  // result checker
  always @(posedge clk_i) begin
    qres_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.status = m_axis_tuser;
      got.word   = m_axis_tdata[63:0];
      got.prio   = m_axis_tdata[95:64];
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word: %p", got);
      end else begin
        want = expected_q.pop_front();
        if (got.status !== want.status || got.word !== want.word || got.prio !== want.prio) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp st=%0d d=%h p=%h got st=%0d d=%h p=%h",
                     want.status, want.word, want.prio, got.status, got.word, got.prio);
        end
      end
    end
  end

  // receiver stalls: random runs, with stall-free stretches
  initial begin
    int stall;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if ($urandom_range(0, 3) == 0) stall = 0;
      else stall = $urandom_range(0, 7);
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      while (!(m_axis_tvalid)) @(posedge clk_i);
    end
  end

  // watchdog on idle cycles
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || done)
      wdog <= 0;
    else begin
      wdog <= wdog + 1;
      if (wdog >= WDOG_LIMIT) begin
        $display("[circular_bucket_priority_queue] ERROR");
        $finish;
      end
    end
  end

  task automatic test_empty_and_extremes();
    deq();
    enq(32'h0, 64'h0);
    enq(32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    enq(NB - 1, 64'hA5A5_5A5A_0F0F_F0F0);
    enq(NB, 64'h5A5A_A5A5_F0F0_0F0F);
    repeat (5) deq();
  endtask

  task automatic test_full_bucket();
    for (int i = 0; i <= DEPTH + 1; i++) enq(base_q + 3, {$urandom, $urandom});
    repeat (DEPTH + 2) deq();
  endtask

  task automatic test_swap_and_clamp();
    // fill the second half only, then pop: swap before pop; then below-window clamp
    enq(base_q + NB + 2, 64'h1111);
    enq(base_q + 2 * NB + 50, 64'h2222);
    deq();
    enq(32'h0, 64'h3333);
    deq();
    deq();
    deq();
  endtask

  task automatic test_random(int n);
    int kind;
    for (int i = 0; i < n; i++) begin
      kind = $urandom_range(0, 9);
      if (kind < 5) enq(base_q + $urandom_range(0, 2 * NB + 4), {$urandom, $urandom});
      else if (kind == 5) enq($urandom, {$urandom, $urandom});
      else if (kind == 6) enq(base_q + $urandom_range(0, 3), {$urandom, $urandom});
      else deq();
      if (i == n / 2) drain_results();
    end
  endtask

  task automatic test_wrap();
    // advance the base by repeated swaps with top-clamped enqueue/dequeue pairs
    for (int i = 0; i < 40; i++) begin
      enq(32'hFFFF_FFFF, {$urandom, $urandom});
      deq();
    end
  endtask

  initial begin
    base_q = '0;
    prim_q = 1'b0;
    occ_q[0] = '0;
    occ_q[1] = '0;
    for (int i = 0; i < 2 * NB; i++) begin
      head_q[i] = '0;
      tail_q[i] = '0;
    end
    for (int i = 0; i < 2 * NB * DEPTH; i++) store_q[i] = '0;
    done = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tuser = OP_ENQ;
    s_axis_tdata = '0;
    rst_ni = 1'b0;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    test_empty_and_extremes();
    test_full_bucket();
    test_swap_and_clamp();
    test_random(560);
    test_wrap();
    drain_results();
    repeat (20) @(negedge clk_i);
    done = 1'b1;
    if (mismatches == 0 && expected_q.size() == 0)
      $display("[circular_bucket_priority_queue] OK");
    else
      $display("[circular_bucket_priority_queue] ERROR");
    $finish;
  end

endmodule

// File: filelist.f
hdl/cbpq_pkg.sv
hdl/cbpq_ptr_mem.sv
hdl/cbpq_store.sv
hdl/circular_bucket_priority_queue.sv
hdl/cbpq_checker.sv
tb/sv/circular_bucket_priority_queue_tb.sv
